FILE: rtl/dps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dps_pkg
// Shared codes and word layouts for the dock power sequencer / I2C slave.
// ----------------------------------------------------------------------------
package dps_pkg;

  // input word kinds
  localparam logic [2:0] ACT_EVAL    = 3'd0;
  localparam logic [2:0] ACT_ADDR    = 3'd1;
  localparam logic [2:0] ACT_RX      = 3'd2;
  localparam logic [2:0] ACT_TX_DONE = 3'd3;
  localparam logic [2:0] ACT_BUS_ERR = 3'd4;

  // dock modes
  localparam logic [2:0] MODE_RESET  = 3'd0;
  localparam logic [2:0] MODE_IDLE   = 3'd1;
  localparam logic [2:0] MODE_DETECT = 3'd2;
  localparam logic [2:0] MODE_LOCK   = 3'd3;
  localparam logic [2:0] MODE_OFF    = 3'd4;
  localparam logic [2:0] MODE_ON     = 3'd5;

  // I2C command bytes and fixed replies
  localparam logic [7:0] CMD_FLAG_WR  = 8'hA0;
  localparam logic [7:0] CMD_STATUS   = 8'hA1;
  localparam logic [7:0] CMD_HOST     = 8'hA2;
  localparam logic [7:0] CMD_VERSION  = 8'hA3;
  localparam logic [7:0] STATUS_REPLY = 8'hDC;
  localparam logic [7:0] FLAG_ALL     = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       master_reads;
    logic       power_request;
    logic       lock_closed;
    logic       cable_present;
    logic [2:0] action;
  } in_item_t;

  typedef struct packed {
    logic       ec_irq_out;
    logic       pcie_power;
    logic       lock_detect_out;
    logic       psu_enable;
    logic       case_led;
    logic       red_led;
    logic       white_led;
    logic [2:0] mode_now;
  } levels_t;

  // I2C side requests into the mode block
  typedef struct packed {
    logic       flag_wr;
    logic [7:0] flag_data;
    logic       irq_clr;
  } cmd_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    levels_t    lv;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/dps_mode_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dps_mode_ctrl
// Six-mode dock machine, output levels and the host flag register.
// ----------------------------------------------------------------------------
module dps_mode_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire dps_pkg::in_item_t item,
  input  wire dps_pkg::cmd_req_t req,
  output logic                   host_flag_zero,
  output dps_pkg::levels_t       lv_next
);

  dps_pkg::levels_t lv;
  logic [7:0]       host_flag;
  logic [7:0]       host_flag_next;
  logic             move;
  logic [2:0]       nxt;
  logic [2:0]       prv;
  logic             flag;

  assign flag           = (host_flag != 8'd0);
  assign host_flag_zero = !flag;
  assign prv            = lv.mode_now;

  always_comb begin
    move = 1'b0;
    nxt  = lv.mode_now;
    if (item.action == dps_pkg::ACT_EVAL) begin
      unique case (lv.mode_now)
        dps_pkg::MODE_RESET: begin
          move = 1'b1; nxt = dps_pkg::MODE_IDLE;
        end
        dps_pkg::MODE_IDLE: begin
          if (!flag) begin move = 1'b1; nxt = dps_pkg::MODE_DETECT; end
        end
        dps_pkg::MODE_DETECT: begin
          if (flag) begin move = 1'b1; nxt = dps_pkg::MODE_IDLE; end
          else if (item.cable_present) begin move = 1'b1; nxt = dps_pkg::MODE_LOCK; end
        end
        dps_pkg::MODE_LOCK: begin
          if (flag) begin move = 1'b1; nxt = dps_pkg::MODE_IDLE; end
          else if (!item.cable_present) begin move = 1'b1; nxt = dps_pkg::MODE_DETECT; end
          else if (item.lock_closed) begin move = 1'b1; nxt = dps_pkg::MODE_OFF; end
        end
        dps_pkg::MODE_OFF: begin
          if (flag) begin move = 1'b1; nxt = dps_pkg::MODE_IDLE; end
          else if (!item.cable_present) begin move = 1'b1; nxt = dps_pkg::MODE_DETECT; end
          else if (!item.lock_closed) begin move = 1'b1; nxt = dps_pkg::MODE_LOCK; end
          else if (item.power_request) begin move = 1'b1; nxt = dps_pkg::MODE_ON; end
        end
        dps_pkg::MODE_ON: begin
          if (flag) begin move = 1'b1; nxt = dps_pkg::MODE_IDLE; end
          else if (!item.cable_present) begin move = 1'b1; nxt = dps_pkg::MODE_DETECT; end
          else if (!item.lock_closed) begin move = 1'b1; nxt = dps_pkg::MODE_LOCK; end
          else if (!item.power_request) begin move = 1'b1; nxt = dps_pkg::MODE_OFF; end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    lv_next        = lv;
    host_flag_next = host_flag;
    if (move) begin
      if (nxt == dps_pkg::MODE_LOCK || nxt == dps_pkg::MODE_OFF) begin
        lv_next.white_led  = 1'b1;
        lv_next.red_led    = 1'b0;
        lv_next.psu_enable = 1'b1;
        lv_next.case_led   = 1'b0;
      end else if (nxt == dps_pkg::MODE_ON) begin
        // psu keeps its level here
        lv_next.white_led = 1'b0;
        lv_next.red_led   = 1'b1;
        lv_next.case_led  = 1'b1;
      end else begin
        lv_next.white_led  = 1'b0;
        lv_next.red_led    = 1'b0;
        lv_next.psu_enable = 1'b0;
        lv_next.case_led   = 1'b0;
      end

      if (nxt > dps_pkg::MODE_LOCK && prv < nxt) lv_next.lock_detect_out = 1'b1;
      else if (nxt <= dps_pkg::MODE_LOCK && prv > nxt) lv_next.lock_detect_out = 1'b0;

      if (prv > dps_pkg::MODE_OFF && nxt <= dps_pkg::MODE_OFF) lv_next.pcie_power = 1'b0;
      else if (prv < dps_pkg::MODE_ON && nxt >= dps_pkg::MODE_ON) lv_next.pcie_power = 1'b1;

      if (prv < dps_pkg::MODE_LOCK && nxt >= dps_pkg::MODE_LOCK) lv_next.ec_irq_out = 1'b1;

      // leaving reset, or dropping from lock/off/on back to idle or detect, flags the host
      if (prv == dps_pkg::MODE_RESET ||
          (prv > dps_pkg::MODE_DETECT && nxt <= dps_pkg::MODE_DETECT)) begin
        host_flag_next = dps_pkg::FLAG_ALL;
      end

      lv_next.mode_now = nxt;
    end
    if (req.irq_clr) lv_next.ec_irq_out = 1'b0;
    if (req.flag_wr) host_flag_next = req.flag_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lv        <= '0;
      host_flag <= 8'd0;
    end else if (fire) begin
      lv        <= lv_next;
      host_flag <= host_flag_next;
    end
  end

`ifndef ASSERT_OFF
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    lv.mode_now <= dps_pkg::MODE_ON)
    else $error("dock mode out of range");

  a_pcie_on_only: assert property (@(posedge clk) disable iff (rst)
    lv.pcie_power == (lv.mode_now == dps_pkg::MODE_ON))
    else $error("pcie power does not track power-on mode");

  a_psu_low: assert property (@(posedge clk) disable iff (rst)
    (lv.mode_now == dps_pkg::MODE_IDLE || lv.mode_now == dps_pkg::MODE_DETECT)
      |-> !lv.psu_enable)
    else $error("psu on with no cable locked");
`endif

endmodule
`default_nettype wire

FILE: rtl/dps_i2c_cmd.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dps_i2c_cmd
// I2C slave command protocol: command, register, size, data, reply phases.
// ----------------------------------------------------------------------------
module dps_i2c_cmd (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire dps_pkg::in_item_t item,
  input  wire logic              host_flag_zero,
  output dps_pkg::cmd_req_t      req,
  output logic [7:0]             tx_byte,
  output logic                   tx_valid
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_REG  = 3'd1,
    PH_SIZE = 3'd2,
    PH_DATA = 3'd3,
    PH_SEND = 3'd4,
    PH_ACK  = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] command_code, command_code_next;
  logic [7:0] register_index, register_index_next;
  logic [7:0] transfer_size, transfer_size_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] reply_data, reply_data_next;
  logic [7:0] rx;

  assign rx = item.rx_byte;

  always_comb begin
    phase_next          = phase;
    command_code_next   = command_code;
    register_index_next = register_index;
    transfer_size_next  = transfer_size;
    bytes_left_next     = bytes_left;
    reply_data_next     = reply_data;
    req                 = '0;
    tx_byte             = 8'd0;
    tx_valid            = 1'b0;
    unique case (item.action)
      dps_pkg::ACT_ADDR: begin
        if (item.master_reads && phase == PH_SEND) begin
          phase_next = PH_ACK;
          tx_byte    = reply_data;
          tx_valid   = 1'b1;
        end else begin
          // write, or read with nothing queued: empty reply
          phase_next = PH_IDLE;
        end
      end
      dps_pkg::ACT_RX: begin
        unique case (phase)
          PH_IDLE: begin
            command_code_next = rx;
            if (rx == dps_pkg::CMD_FLAG_WR) begin
              phase_next = PH_REG;
            end else if (rx == dps_pkg::CMD_STATUS || rx == dps_pkg::CMD_HOST ||
                         rx == dps_pkg::CMD_VERSION) begin
              register_index_next = 8'd0;
              transfer_size_next  = 8'd1;
              if (rx == dps_pkg::CMD_STATUS) begin
                req.irq_clr     = 1'b1;
                reply_data_next = dps_pkg::STATUS_REPLY;
              end else if (rx == dps_pkg::CMD_HOST) begin
                reply_data_next = host_flag_zero ? 8'd2 : 8'd1;
              end else begin
                reply_data_next = 8'd1;
              end
              phase_next = PH_SEND;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_REG: begin
            register_index_next = rx;
            phase_next          = PH_SIZE;
          end
          PH_SIZE: begin
            transfer_size_next = rx;
            bytes_left_next    = rx;
            phase_next         = PH_DATA;
          end
          PH_DATA: begin
            if (bytes_left > 8'd1) begin
              bytes_left_next = bytes_left - 8'd1;
            end else begin
              bytes_left_next = 8'd0;
              if (command_code == dps_pkg::CMD_FLAG_WR && transfer_size == 8'd1 &&
                  register_index == 8'd1) begin
                req.flag_wr   = 1'b1;
                req.flag_data = rx;
              end
              phase_next = PH_IDLE;
            end
          end
          default: ;  // stray byte
        endcase
      end
      dps_pkg::ACT_TX_DONE, dps_pkg::ACT_BUS_ERR: phase_next = PH_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      command_code   <= 8'd0;
      register_index <= 8'd0;
      transfer_size  <= 8'd0;
      bytes_left     <= 8'd0;
      reply_data     <= 8'd0;
    end else if (fire) begin
      phase          <= phase_next;
      command_code   <= command_code_next;
      register_index <= register_index_next;
      transfer_size  <= transfer_size_next;
      bytes_left     <= bytes_left_next;
      reply_data     <= reply_data_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dock_power_sequencer_i2c_slave.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dock_power_sequencer_i2c_slave
// Dock power sequencer with I2C slave command handling, one result per word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tuser action, s_tdata levels+byte
//  m_*     | out       | m_tvalid/m_tready  | m_tdata mode, levels, reply byte
//
//  One word per cycle sustained while m_tready stays high; an accepted word
//  goes to the input register, then to the result register.
//  All mode and protocol state updates in the single cycle a word moves
//  from the input register to the result register.
//  rst (synchronous) clears both valid flags and all mode and protocol state.
//  m_tready low holds the result; the input register still takes one word.
module dock_power_sequencer_i2c_slave (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [0] cable_present, [1] lock_closed, [2] power_request, [3] master_reads,
  // [11:4] rx_byte, [15:12] zero
  input  wire logic [15:0] s_tdata,
  // [2:0] action
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] mode_now, [3] white_led, [4] red_led, [5] case_led, [6] psu_enable,
  // [7] lock_detect_out, [8] pcie_power, [9] ec_irq_out, [17:10] tx_byte,
  // [18] tx_valid, [23:19] zero
  output logic [23:0]      m_tdata
);

  dps_pkg::in_item_t  a_item;
  logic               a_valid;
  logic               a_advance;
  dps_pkg::out_item_t b_item;
  logic               b_valid;
  dps_pkg::cmd_req_t  req;
  dps_pkg::levels_t   lv_next;
  logic               host_flag_zero;
  logic [7:0]         tx_byte;
  logic               tx_valid;

  assign a_advance = a_valid && (!b_valid || m_tready);
  assign s_tready  = !a_valid || a_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_item <= {s_tdata[11:0], s_tuser};
    end
  end

  dps_mode_ctrl u_mode (
    .clk            (clk),
    .rst            (rst),
    .fire           (a_advance),
    .item           (a_item),
    .req            (req),
    .host_flag_zero (host_flag_zero),
    .lv_next        (lv_next)
  );

  dps_i2c_cmd u_i2c (
    .clk            (clk),
    .rst            (rst),
    .fire           (a_advance),
    .item           (a_item),
    .host_flag_zero (host_flag_zero),
    .req            (req),
    .tx_byte        (tx_byte),
    .tx_valid       (tx_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_advance) begin
      b_valid <= 1'b1;
    end else if (m_tready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      b_item <= '{tx_valid: tx_valid, tx_byte: tx_byte, lv: lv_next};
    end
  end

  assign m_tvalid = b_valid;
  assign m_tdata  = {5'd0, b_item};

`ifndef ASSERT_OFF
  a_empty_reply: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_item.tx_valid) |-> (b_item.tx_byte == 8'd0))
    else $error("reply byte set without tx_valid");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    a_advance |=> b_valid)
    else $error("processed word produced no result");
`endif

endmodule
`default_nettype wire
